>>> hw/rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
// Used by lkvc_cell and lru_key_value_cache; depends on nothing.
package lkvc_pkg;

  // Built depth of the store
  localparam int MAX_ENTRIES = 8;
  localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = RANK_W + 1;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  // Operation codes carried on the input tuser
  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Command from the sequencer to every cell
  typedef struct packed {
    logic              search;    // capture match and first-free flags
    logic              update;    // apply write and recency update
    logic              any_hit;   // key was found in some cell
    logic              insert;    // miss with room left: fill first free cell
    logic [CNT_W-1:0]  old_rank;  // cells younger than this age by one
  } lkvc_cmd_t;

  // Data passed from cell to cell along the row
  typedef struct packed {
    logic              free_seen; // an earlier cell is free
    logic              hit;       // an earlier cell matched
    logic [RANK_W-1:0] rank;      // rank of the matching cell
    logic [VAL_W-1:0]  value;     // value of the matching cell
  } lkvc_chain_t;

  // Capacity register clamped to 1..MAX_ENTRIES
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (cap == '0) begin
      res = CNT_W'(1);
    end else if (int'(cap) > MAX_ENTRIES) begin
      res = CNT_W'(MAX_ENTRIES);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/lkvc_cell.sv
// One entry of the LRU cache: key, value, valid mark and recency rank.
// Depends on lkvc_pkg; instantiated in a row by lru_key_value_cache.
module lkvc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [lkvc_pkg::KEY_W-1:0]       key_i,
  input  logic [lkvc_pkg::VAL_W-1:0]       val_i,
  input  lkvc_pkg::lkvc_cmd_t              cmd_i,
  input  lkvc_pkg::lkvc_chain_t            chain_i,
  output lkvc_pkg::lkvc_chain_t            chain_o
);

  logic [lkvc_pkg::KEY_W-1:0]  key_q;
  logic [lkvc_pkg::VAL_W-1:0]  val_q;
  logic                        valid_q, valid_d;
  logic [lkvc_pkg::RANK_W-1:0] rank_q, rank_d;
  logic                        hit_q, first_free_q;
  logic                        match;
  logic                        sel;
  logic                        younger;
  logic [lkvc_pkg::CNT_W-1:0]  rank_ext;

  assign match    = valid_q && (key_q == key_i);
  assign rank_ext = {1'b0, rank_q};

  // Pass match and free-slot information to the next cell
  always_comb begin
    chain_o.free_seen = chain_i.free_seen | ~valid_q;
    chain_o.hit       = chain_i.hit | match;
    chain_o.rank      = chain_i.rank | (match ? rank_q : '0);
    chain_o.value     = chain_i.value | (match ? val_q : '0);
  end

  // Cell chosen for the write: matching, first free, or the LRU one
  always_comb begin
    if (cmd_i.any_hit) begin
      sel = hit_q;
    end else if (cmd_i.insert) begin
      sel = first_free_q;
    end else begin
      sel = valid_q && (rank_ext == cmd_i.old_rank);
    end
  end

  assign younger = valid_q && (rank_ext < cmd_i.old_rank);

  // Recency and valid update
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (cmd_i.update) begin
      if (sel) begin
        valid_d = 1'b1;
        rank_d  = '0;
      end else if (younger) begin
        rank_d  = rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      rank_q       <= '0;
      hit_q        <= 1'b0;
      first_free_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      if (cmd_i.search) begin
        hit_q        <= match;
        first_free_q <= ~valid_q & ~chain_i.free_seen;
      end
    end
  end

  // Payload write
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && sel) begin
      key_q <= key_i;
      val_q <= val_i;
    end
  end

endmodule

>>> hw/rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: stream ports, sequencer, cell row.
// Depends on lkvc_pkg and lkvc_cell.
//
// Usage:
//   Input beats arrive on s_axis: tuser is the operation (0 set, 1 get),
//   tdata holds key_in in bits 31:0 and value_in in bits 63:32.
//   A get produces one output beat on m_axis: tuser is the hit flag and
//   tdata is the stored value, or zero on a miss. A set produces no beat.
//   Capacity (1..8, 0 acts as 1) is written through cfg_we_i/cfg_wdata_i
//   while the block is idle.
// Sequencing:
//   Each beat passes through a search state, which compares the key against
//   every cell of the row, and an update state, which for a set writes the
//   entry and the recency ranks. A new beat is taken in the update state of
//   the previous one; a get result enters the output register as it ends.
// Reset and stall:
//   Reset clears all valid marks, ranks and occupancy; capacity returns to 8.
//   If a get reaches its update cycle while the previous result still waits
//   in the output register, it holds there and input stops until the waiting
//   result is taken. A set never holds.
module lru_key_value_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,     // capacity
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,    // [31:0] key_in, [63:32] value_in
  input  logic        s_axis_tuser,    // [0] op
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [31:0] value_out
  output logic        m_axis_tuser     // [0] hit
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic                          op_q;
  logic [lkvc_pkg::KEY_W-1:0]    key_q;
  logic [lkvc_pkg::VAL_W-1:0]    val_q;
  logic [lkvc_pkg::CAP_W-1:0]    cap_q;
  logic [lkvc_pkg::CNT_W-1:0]    occ_q, occ_d;
  logic                          any_hit_q;
  logic [lkvc_pkg::RANK_W-1:0]   hit_rank_q;
  logic [lkvc_pkg::VAL_W-1:0]    hit_val_q;
  logic                          out_valid_q, out_valid_d;
  logic                          out_hit_q;
  logic [lkvc_pkg::VAL_W-1:0]    out_val_q;
  logic                          in_fire;
  logic                          finish;
  logic                          insert;
  lkvc_pkg::lkvc_cmd_t           cmd;
  lkvc_pkg::lkvc_chain_t         chain [lkvc_pkg::MAX_ENTRIES+1];

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Update cycle completes unless a get result cannot be stored
  assign finish  = (state_q == ST_UPDATE) &&
                   ((op_q == lkvc_pkg::OP_SET) || !out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || finish;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Miss with room left inserts, otherwise a miss evicts
  assign insert = !any_hit_q && (occ_q < lkvc_pkg::eff_cap(cap_q));

  // Command to the cell row
  always_comb begin
    cmd.search  = (state_q == ST_SEARCH);
    cmd.update  = finish && (op_q == lkvc_pkg::OP_SET);
    cmd.any_hit = any_hit_q;
    cmd.insert  = insert;
    if (any_hit_q) begin
      cmd.old_rank = {1'b0, hit_rank_q};
    end else if (insert) begin
      cmd.old_rank = occ_q;
    end else begin
      cmd.old_rank = occ_q - 1'b1;
    end
  end

  // Row of cells
  assign chain[0] = '0;
  for (genvar g = 0; g < lkvc_pkg::MAX_ENTRIES; g++) begin : g_cell
    lkvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .val_i   (val_q),
      .cmd_i   (cmd),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (in_fire) begin
          state_d = ST_SEARCH;
        end else if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Occupancy grows on each inserting set
  always_comb begin
    occ_d = occ_q;
    if (cmd.update && insert) occ_d = occ_q + 1'b1;
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish && (op_q == lkvc_pkg::OP_GET)) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      any_hit_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_SEARCH) any_hit_q <= chain[lkvc_pkg::MAX_ENTRIES].hit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= s_axis_tuser;
      key_q <= s_axis_tdata[31:0];
      val_q <= s_axis_tdata[63:32];
    end
    if (state_q == ST_SEARCH) begin
      hit_rank_q <= chain[lkvc_pkg::MAX_ENTRIES].rank;
      hit_val_q  <= chain[lkvc_pkg::MAX_ENTRIES].value;
    end
    if (finish && (op_q == lkvc_pkg::OP_GET)) begin
      out_hit_q <= any_hit_q;
      out_val_q <= any_hit_q ? hit_val_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = out_val_q;

endmodule
